/* design/bal_pkg.sv */
// Shared constants, types and payload structs for the bounded array list unit.
package bal_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 4;
  localparam int POS_W     = 4;
  localparam int OUT_CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_SORTED = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_ALL    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // How a cell decides that it is the target position.
  typedef enum logic [2:0] {
    MK_NONE,
    MK_ZERO,
    MK_COUNT,
    MK_LAST,
    MK_POS,
    MK_EQ,
    MK_SORT
  } mark_mode_t;

  typedef struct packed {
    cell_op_t                 op;
    mark_mode_t               mode;
    logic signed [WORD_W-1:0] key;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
  } cell_ctrl_t;

  // Passed from cell to cell: target seen so far, and the word at the target.
  typedef struct packed {
    logic                     after;
    logic signed [WORD_W-1:0] pick;
  } chain_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic                     found;
    logic signed [WORD_W-1:0] element;
    logic [OUT_CNT_W-1:0]     removed_count;
    logic [OUT_CNT_W-1:0]     entry_count;
  } rsp_t;

endpackage

/* design/bal_cell.sv */
// One list slot: holds a word, finds the target position and shifts with its neighbors.
module bal_cell (
  input  logic                              clk,
  input  logic [bal_pkg::IDX_W-1:0]         index,
  input  bal_pkg::cell_ctrl_t               ctrl,
  input  logic signed [bal_pkg::WORD_W-1:0] left_word,
  input  logic signed [bal_pkg::WORD_W-1:0] right_word,
  input  bal_pkg::chain_t                   chain_in,
  output bal_pkg::chain_t                   chain_out,
  output logic signed [bal_pkg::WORD_W-1:0] word
);
  import bal_pkg::*;

  logic             valid;
  logic             eq;
  logic             gt;
  logic             mark_raw;
  logic             mark;
  logic             at;
  logic [CNT_W-1:0] idx_c;

  assign idx_c = CNT_W'(index);
  assign valid = idx_c < ctrl.count;
  assign eq    = valid && (word == ctrl.key);
  assign gt    = valid && (word > ctrl.key);

  always_comb begin
    unique case (ctrl.mode)
      MK_NONE:  mark_raw = 1'b0;
      MK_ZERO:  mark_raw = (index == '0);
      MK_COUNT: mark_raw = (idx_c == ctrl.count);
      MK_LAST:  mark_raw = ((idx_c + CNT_W'(1)) == ctrl.count);
      MK_POS:   mark_raw = (32'(index) == 32'(ctrl.position));
      MK_EQ:    mark_raw = eq;
      MK_SORT:  mark_raw = gt || (idx_c == ctrl.count);
      default:  mark_raw = 1'b0;
    endcase
  end

  // inserts may target the first free slot; everything else only valid slots
  assign mark = (ctrl.op == CELL_INS) ? mark_raw : (mark_raw && valid);
  assign at   = mark && !chain_in.after;

  assign chain_out.after = chain_in.after || mark;
  assign chain_out.pick  = at ? word : chain_in.pick;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INS: begin
        if (at) begin
          word <= ctrl.key;
        end else if (chain_in.after) begin
          word <= left_word;
        end
      end
      CELL_DEL: begin
        if (chain_out.after) begin
          word <= right_word;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/bounded_array_list_unit.sv */
// Top level of the bounded array list unit: command sequencer around a row of list cells.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one command: insert front,
//   rear or sorted, delete front, rear, at position, first match or all matches, search.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns one result per command:
//   ok, found, element, removed_count and entry_count after the command.
//   Words live in a row of DEPTH cells; every cell compares its word with the key and
//   the row shifts right (insert) or left (delete) from the target on, the target found by a
//   flag passed from cell to cell.
// Timing:
//   A command is taken in ST_IDLE and executed in ST_RUN from the next cycle; the result
//   is registered and shows on rsp once the output slot is free. A new command is not
//   taken until the last is done. Delete all matches removes one match per execute cycle.
//   req_stall is high while a command is in progress.
// Reset: rst empties the list and drops any pending result.
// Stall: while rsp_stall holds a result, one more command is taken and executed; its
//   result waits in a holding register and no further command is taken until it moves.
module bounded_array_list_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bal_pkg::req_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bal_pkg::rsp_t   rsp_data
);
  import bal_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [CMD_W-1:0]         cmd_r;
  logic signed [WORD_W-1:0] key_r;
  logic [POS_W-1:0]         pos_r;
  logic                     ok_pre;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         removed_r;
  logic [CNT_W-1:0]         removed_next;
  rsp_t                     res;
  rsp_t                     res_r;
  logic                     done;
  logic                     full;
  logic                     accept;
  logic                     slot_free;
  logic                     load_out;
  logic                     hit;
  logic signed [WORD_W-1:0] pick;
  cell_ctrl_t               ctrl;

  logic signed [WORD_W-1:0] words [DEPTH];
  chain_t                   chain [DEPTH+1];

  assign full      = (count == CNT_W'(DEPTH));
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign load_out  = ((state == ST_RUN) && done && slot_free) ||
                     ((state == ST_WAIT) && slot_free);
  assign hit       = chain[DEPTH].after;
  assign pick      = chain[DEPTH].pick;
  assign chain[0]  = '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      bal_cell u_cell (
        .clk        (clk),
        .index      (IDX_W'(gi)),
        .ctrl       (ctrl),
        .left_word  ((gi == 0) ? key_r : words[(gi == 0) ? 0 : gi - 1]),
        .right_word ((gi == DEPTH - 1) ? words[gi] : words[(gi == DEPTH - 1) ? gi : gi + 1]),
        .chain_in   (chain[gi]),
        .chain_out  (chain[gi + 1]),
        .word       (words[gi])
      );
    end
  endgenerate

  // cell control decode
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.mode     = MK_NONE;
    ctrl.key      = key_r;
    ctrl.position = pos_r;
    ctrl.count    = count;
    if (state == ST_RUN) begin
      unique case (cmd_r)
        CMD_INS_FRONT: begin
          ctrl.op   = full ? CELL_HOLD : CELL_INS;
          ctrl.mode = full ? MK_NONE : MK_ZERO;
        end
        CMD_INS_REAR: begin
          ctrl.op   = full ? CELL_HOLD : CELL_INS;
          ctrl.mode = full ? MK_NONE : MK_COUNT;
        end
        CMD_INS_SORTED: begin
          ctrl.op   = full ? CELL_HOLD : CELL_INS;
          ctrl.mode = full ? MK_NONE : MK_SORT;
        end
        CMD_DEL_FRONT: begin
          ctrl.op   = CELL_DEL;
          ctrl.mode = MK_ZERO;
        end
        CMD_DEL_REAR: begin
          ctrl.op   = CELL_DEL;
          ctrl.mode = MK_LAST;
        end
        CMD_DEL_AT: begin
          ctrl.op   = CELL_DEL;
          ctrl.mode = MK_POS;
        end
        CMD_DEL_FIRST, CMD_DEL_ALL: begin
          ctrl.op   = CELL_DEL;
          ctrl.mode = MK_EQ;
        end
        CMD_SEARCH: begin
          ctrl.op   = CELL_HOLD;
          ctrl.mode = MK_EQ;
        end
        default: ;
      endcase
    end
  end

  // result and count update
  always_comb begin
    res          = '0;
    done         = 1'b1;
    count_next   = count;
    removed_next = removed_r;
    if (state == ST_RUN) begin
      unique case (cmd_r)
        CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_SORTED: begin
          if (!full) begin
            res.ok     = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_AT, CMD_DEL_FIRST: begin
          res.ok = (cmd_r == CMD_DEL_FIRST) ? (count != '0) : hit;
          if (hit) begin
            res.found         = 1'b1;
            res.element       = pick;
            res.removed_count = OUT_CNT_W'(1);
            count_next        = count - CNT_W'(1);
          end
        end
        CMD_DEL_ALL: begin
          if (hit) begin
            done         = 1'b0;
            count_next   = count - CNT_W'(1);
            removed_next = removed_r + CNT_W'(1);
          end else begin
            res.ok            = ok_pre;
            res.found         = (removed_r != '0);
            res.element       = (removed_r != '0) ? key_r : '0;
            res.removed_count = OUT_CNT_W'(removed_r);
          end
        end
        CMD_SEARCH: begin
          res.ok      = 1'b1;
          res.found   = hit;
          res.element = hit ? pick : '0;
        end
        default: ;
      endcase
    end
    res.entry_count = OUT_CNT_W'(count_next);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_next = slot_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= req_data.command;
      key_r     <= req_data.value;
      pos_r     <= req_data.position;
      ok_pre    <= (count != '0);
      removed_r <= '0;
    end else if (state == ST_RUN) begin
      removed_r <= removed_next;
    end
    if ((state == ST_RUN) && done) begin
      res_r <= res;
    end
    if (load_out) begin
      rsp_data <= (state == ST_WAIT) ? res_r : res;
    end
  end

endmodule
